/* rtl/ywa_pkg.sv */
// Shared types, constants and the arctangent table for the yaw window average.
// No dependencies; ywa_cordic, ywa_window and yaw_window_average import this package.
package ywa_pkg;

  localparam int QW           = 16;  // quaternion part and yaw width
  localparam int VW           = 36;  // CORDIC vector width
  localparam int ACW          = 20;  // angle accumulator, two guard bits
  localparam int CNT_W        = 4;   // sample count width
  localparam int THR_W        = 15;  // jump threshold width
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 15;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 4;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_THRESHOLD = 2'd1;

  localparam logic [CNT_W-1:0] WINDOW_LENGTH_RST  = 4'd8;
  localparam logic [THR_W-1:0] JUMP_THRESHOLD_RST = 15'd104;

  typedef struct packed {
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [QW-1:0] yaw_now;
    logic signed [QW-1:0] yaw_mean;
    logic [CNT_W-1:0]     sample_count;
    logic                 window_full;
    logic                 window_cleared;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0] window_length;
    logic [THR_W-1:0] jump_threshold;
  } cfg_t;

  // atan(2^-i), units of pi/131072
  function automatic logic [15:0] atan_lut(input logic [STEP_W-1:0] i);
    logic [15:0] v;
    case (i)
      4'd0:    v = 16'd32768;
      4'd1:    v = 16'd19344;
      4'd2:    v = 16'd10221;
      4'd3:    v = 16'd5188;
      4'd4:    v = 16'd2604;
      4'd5:    v = 16'd1303;
      4'd6:    v = 16'd652;
      4'd7:    v = 16'd326;
      4'd8:    v = 16'd163;
      4'd9:    v = 16'd81;
      4'd10:   v = 16'd41;
      4'd11:   v = 16'd20;
      4'd12:   v = 16'd10;
      4'd13:   v = 16'd5;
      4'd14:   v = 16'd3;
      default: v = 16'd1;
    endcase
    return v;
  endfunction

endpackage

/* rtl/ywa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ywa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ywa_fifo.sv */
// Small register queue carrying yaw items from the CORDIC front to the window back.
// No dependencies.
module ywa_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = buf_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/ywa_cordic.sv */
// Front: accepts a quaternion, forms the yaw vector with one shared multiplier,
// then runs a 16-step vectoring CORDIC. Depends on ywa_pkg.
module ywa_cordic import ywa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  quat_t                quat_i,
  output logic                 busy_o,
  output logic                 yaw_valid_o,
  output logic signed [QW-1:0] yaw_o,
  input  logic                 yaw_ready_i
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_ROT  = 2'd2;
  localparam logic [1:0] F_DONE = 2'd3;

  localparam logic [STEP_W-1:0] MUL_LAST = 4'd6;  // extra step does the quadrant fix
  localparam logic [STEP_W-1:0] ROT_LAST = STEP_W'(CORDIC_STEPS - 1);

  logic [1:0]            state_q, state_d;
  logic [STEP_W-1:0]     step_q, step_d;
  quat_t                 quat_q;
  logic signed [VW-1:0]  vx_q, vx_d, vy_q, vy_d;
  logic signed [ACW-1:0] acc_q, acc_d;
  logic                  zero_q, zero_d;

  logic signed [QW-1:0]  mul_a, mul_b;
  logic signed [31:0]    prod;
  logic signed [VW-1:0]  prod_x, dx, dy, lut_x;
  logic signed [ACW-1:0] lut_a, rnd;

  always_comb begin
    case (step_q)
      4'd0:    begin mul_a = quat_q.quat_w; mul_b = quat_q.quat_w; end
      4'd1:    begin mul_a = quat_q.quat_x; mul_b = quat_q.quat_x; end
      4'd2:    begin mul_a = quat_q.quat_y; mul_b = quat_q.quat_y; end
      4'd3:    begin mul_a = quat_q.quat_z; mul_b = quat_q.quat_z; end
      4'd4:    begin mul_a = quat_q.quat_x; mul_b = quat_q.quat_y; end
      default: begin mul_a = quat_q.quat_w; mul_b = quat_q.quat_z; end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign prod_x = VW'(prod);
  assign dx     = vy_q >>> step_q;
  assign dy     = vx_q >>> step_q;
  assign lut_a  = signed'(ACW'(atan_lut(step_q)));
  assign lut_x  = '0;
  assign rnd    = acc_q + ACW'(2);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    vx_d    = vx_q;
    vy_d    = vy_q;
    acc_d   = acc_q;
    zero_d  = zero_q;
    case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          state_d = F_MUL;
          step_d  = '0;
          vx_d    = '0;
          vy_d    = '0;
        end
      end
      F_MUL: begin
        step_d = step_q + 1'b1;
        case (step_q)
          4'd0, 4'd1: vx_d = vx_q + prod_x;
          4'd2, 4'd3: vx_d = vx_q - prod_x;
          4'd4, 4'd5: vy_d = vy_q + (prod_x <<< 1);
          default: begin
            zero_d  = (vx_q == lut_x) && (vy_q == lut_x);
            acc_d   = '0;
            step_d  = '0;
            state_d = F_ROT;
            if (vx_q[VW-1]) begin
              if (!vy_q[VW-1]) begin
                vx_d  = vy_q;
                vy_d  = -vx_q;
                acc_d = ACW'(65536);
              end else begin
                vx_d  = -vy_q;
                vy_d  = vx_q;
                acc_d = -ACW'(65536);
              end
            end
          end
        endcase
        if (step_q == MUL_LAST) begin
          state_d = F_ROT;
        end
      end
      F_ROT: begin
        if (!vy_q[VW-1]) begin
          vx_d  = vx_q + dx;
          vy_d  = vy_q - dy;
          acc_d = acc_q + lut_a;
        end else begin
          vx_d  = vx_q - dx;
          vy_d  = vy_q + dy;
          acc_d = acc_q - lut_a;
        end
        step_d = step_q + 1'b1;
        if (step_q == ROT_LAST) begin
          state_d = F_DONE;
        end
      end
      F_DONE: begin
        if (yaw_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && in_valid_i) begin
      quat_q <= quat_i;
    end
    vx_q   <= vx_d;
    vy_q   <= vy_d;
    acc_q  <= acc_d;
    zero_q <= zero_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign busy_o      = (state_q != F_IDLE);
  assign yaw_valid_o = (state_q == F_DONE);
  assign yaw_o       = zero_q ? '0 : rnd[QW+1:2];

endmodule

/* rtl/ywa_window.sv */
// Back: sliding window over yaw samples (ring in ywa_ram), jump clearing,
// running sum and a bit-serial divider for the mean. Depends on ywa_pkg, ywa_ram.
module ywa_window import ywa_pkg::*; #(
  parameter int WINDOW_MAX = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 yaw_valid_i,
  input  logic signed [QW-1:0] yaw_i,
  output logic                 yaw_pop_o,
  output result_t              res_o,
  output logic                 res_valid_o,
  input  logic                 res_pop_i
);

  localparam int IDX_W = WINDOW_MAX > 1 ? $clog2(WINDOW_MAX) : 1;
  localparam int OW    = IDX_W + 2;
  localparam int SUM_W = QW + $clog2(WINDOW_MAX);
  localparam int DC_W  = $clog2(SUM_W);

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_CHECK = 3'd1;
  localparam logic [2:0] B_READ  = 3'd2;
  localparam logic [2:0] B_DIV   = 3'd3;
  localparam logic [2:0] B_FIN   = 3'd4;

  logic [2:0]              state_q;
  logic signed [QW-1:0]    yaw_q, last_q;
  logic [IDX_W-1:0]        ws_q;
  logic [CNT_W-1:0]        hc_q, len_q;
  logic signed [SUM_W-1:0] sum_q;
  logic                    cleared_q, neg_q;
  logic [CNT_W-1:0]        rem_q;
  logic [SUM_W-1:0]        quo_q;
  logic [DC_W-1:0]         dc_q;
  result_t                 res_q;
  logic                    res_valid_q;

  logic [CNT_W-1:0]        len_eff, hc_chk, hc_new;
  logic signed [QW:0]      diff;
  logic [QW:0]             diff_mag;
  logic                    jump, drop, take, ge;
  logic [OW-1:0]           old_sum, old_idx;
  logic [QW-1:0]           rdata;
  logic signed [SUM_W-1:0] sum_new, old_x, yaw_x;
  logic [CNT_W:0]          trial, trial_sub;
  logic [SUM_W-1:0]        mean_w;

  always_comb begin
    if (cfg_i.window_length == '0) begin
      len_eff = CNT_W'(1);
    end else if (int'(cfg_i.window_length) > WINDOW_MAX) begin
      len_eff = CNT_W'(WINDOW_MAX);
    end else begin
      len_eff = cfg_i.window_length;
    end
  end

  assign take     = (state_q == B_IDLE) && yaw_valid_i && !res_valid_q;
  assign diff     = {yaw_q[QW-1], yaw_q} - {last_q[QW-1], last_q};
  assign diff_mag = diff[QW] ? (QW+1)'(0) - diff : diff;
  assign jump     = (hc_q != '0) && (diff_mag > (QW+1)'(cfg_i.jump_threshold));
  assign hc_chk   = jump ? '0 : hc_q;

  // oldest entry sits hc slots behind the write slot
  assign old_sum = OW'(ws_q) + OW'(WINDOW_MAX) - OW'(hc_chk);
  assign old_idx = (old_sum >= OW'(WINDOW_MAX)) ? old_sum - OW'(WINDOW_MAX) : old_sum;

  assign drop    = (hc_q >= len_q);
  assign old_x   = SUM_W'(signed'(rdata));
  assign yaw_x   = SUM_W'(yaw_q);
  assign sum_new = sum_q - (drop ? old_x : '0) + yaw_x;
  assign hc_new  = drop ? hc_q : hc_q + 1'b1;

  assign trial     = {rem_q, quo_q[SUM_W-1]};
  assign ge        = (trial >= {1'b0, hc_q});
  assign trial_sub = trial - {1'b0, hc_q};
  assign mean_w    = neg_q ? SUM_W'(0) - quo_q : quo_q;

  ywa_ram #(
    .WIDTH(QW),
    .DEPTH(WINDOW_MAX)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (state_q == B_READ),
    .waddr_i(ws_q),
    .wdata_i(yaw_q),
    .re_i   (state_q == B_CHECK),
    .raddr_i(old_idx[IDX_W-1:0]),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (take) begin
          yaw_q <= yaw_i;
        end
      end
      B_CHECK: begin
        cleared_q <= jump;
        len_q     <= len_eff;
      end
      B_READ: begin
        quo_q <= sum_new[SUM_W-1] ? SUM_W'(0) - sum_new : sum_new;
        neg_q <= sum_new[SUM_W-1];
        rem_q <= '0;
      end
      B_DIV: begin
        rem_q <= ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
        quo_q <= {quo_q[SUM_W-2:0], ge};
      end
      B_FIN: begin
        res_q.yaw_now        <= yaw_q;
        res_q.yaw_mean       <= mean_w[QW-1:0];
        res_q.sample_count   <= hc_q;
        res_q.window_full    <= (hc_q == len_q);
        res_q.window_cleared <= cleared_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      ws_q        <= '0;
      hc_q        <= '0;
      sum_q       <= '0;
      last_q      <= '0;
      dc_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (res_pop_i && res_valid_q) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (take) begin
            state_q <= B_CHECK;
          end
        end
        B_CHECK: begin
          hc_q <= hc_chk;
          if (jump) begin
            sum_q <= '0;
          end
          state_q <= B_READ;
        end
        B_READ: begin
          sum_q   <= sum_new;
          hc_q    <= hc_new;
          last_q  <= yaw_q;
          ws_q    <= (ws_q == IDX_W'(WINDOW_MAX - 1)) ? '0 : ws_q + 1'b1;
          dc_q    <= DC_W'(SUM_W - 1);
          state_q <= B_DIV;
        end
        B_DIV: begin
          dc_q <= dc_q - 1'b1;
          if (dc_q == '0) begin
            state_q <= B_FIN;
          end
        end
        B_FIN: begin
          res_valid_q <= 1'b1;
          state_q     <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign yaw_pop_o   = take;
  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(hc_q) <= WINDOW_MAX)
    else $error("held count above window size");

  a_result_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_q.sample_count != '0))
    else $error("result with empty window");

  a_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_READ) |=> (hc_q != '0) && (last_q == $past(yaw_q)))
    else $error("sample not appended");

endmodule

/* rtl/yaw_window_average.sv */
// Yaw extraction from an attitude quaternion and sliding-window mean of the yaw.
// Front: multiply sequence on the shared multiplier plus 16-step CORDIC; it takes
// no new quaternion until its yaw has entered the queue. Back: window update and
// a bit-serial divider for the mean; it takes the next yaw only once the previous
// result has been popped.
// Reset (asynchronous, active low) empties the window; no clearing pass.
module yaw_window_average import ywa_pkg::*; #(
  parameter int WINDOW_MAX = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  quat_t                 quat_i,
  output logic                  empty,
  input  logic                  pop,
  output result_t               result_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t                 cfg_q;
  logic                 busy, yaw_valid, fifo_full, fifo_empty, fifo_pop, res_valid;
  logic signed [QW-1:0] yaw_front, yaw_back;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_length  <= WINDOW_LENGTH_RST;
      cfg_q.jump_threshold <= JUMP_THRESHOLD_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_WINDOW_LENGTH:  cfg_q.window_length  <= cfg_data_i[CNT_W-1:0];
        REG_JUMP_THRESHOLD: cfg_q.jump_threshold <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  ywa_cordic u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (push),
    .quat_i     (quat_i),
    .busy_o     (busy),
    .yaw_valid_o(yaw_valid),
    .yaw_o      (yaw_front),
    .yaw_ready_i(!fifo_full)
  );

  ywa_fifo #(
    .WIDTH(QW),
    .DEPTH(2)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (yaw_valid),
    .data_i (yaw_front),
    .full_o (fifo_full),
    .pop_i  (fifo_pop),
    .data_o (yaw_back),
    .empty_o(fifo_empty)
  );

  ywa_window #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .yaw_valid_i(!fifo_empty),
    .yaw_i      (yaw_back),
    .yaw_pop_o  (fifo_pop),
    .res_o      (result_o),
    .res_valid_o(res_valid),
    .res_pop_i  (pop)
  );

  assign full  = busy;
  assign empty = !res_valid;

endmodule
